>>> design/usd_pkg.sv
// ----------------------------------------------------------------------------
// usd_pkg: shared types and constants of the UTF-8 stream decoder
// Byte classes passed from the front end to the decode back end, the
// queue entry layout and the channel payload structs.
// ----------------------------------------------------------------------------
package usd_pkg;

  localparam int unsigned CpW   = 21;
  localparam int unsigned MinW  = 17;
  localparam int unsigned BitsW = 7;

  localparam logic [CpW-1:0]  ReplacementCp = 21'h00FFFD;
  localparam logic [CpW-1:0]  MaxScalar     = 21'h10FFFF;
  localparam logic [CpW-1:0]  SurrLo        = 21'h00D800;
  localparam logic [CpW-1:0]  SurrHi        = 21'h00DFFF;
  localparam logic [MinW-1:0] Min2          = 17'h00080;
  localparam logic [MinW-1:0] Min3          = 17'h00800;
  localparam logic [MinW-1:0] Min4          = 17'h10000;

  // Input operation codes
  typedef enum logic {
    OP_DATA  = 1'b0,
    OP_FLUSH = 1'b1
  } usd_op_e;

  // Byte class decided by the front end
  typedef enum logic [2:0] {
    K_ASCII,
    K_CONT,
    K_LEAD2,
    K_LEAD3,
    K_LEAD4,
    K_BAD,
    K_FLUSH
  } usd_kind_e;

  // Queue entry: class plus the payload bits of the byte, already masked
  typedef struct packed {
    usd_kind_e        kind;
    logic [BitsW-1:0] bits;
  } usd_entry_t;

  // Head of the queue as seen by the back end
  typedef struct packed {
    logic       valid;
    usd_entry_t entry;
  } usd_head_t;

  // Channel payloads
  typedef struct packed {
    logic       operation;
    logic [7:0] data_byte;
  } usd_in_t;

  typedef struct packed {
    logic [CpW-1:0] code_point;
    logic           last_of_run;
  } usd_out_t;

endpackage

>>> design/usd_chan_if.sv
// ----------------------------------------------------------------------------
// usd_chan_if: valid/ready channel
// Carries one request per accepted handshake; payload type is set per use.
// ----------------------------------------------------------------------------
interface usd_chan_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

>>> design/usd_front.sv
// ----------------------------------------------------------------------------
// usd_front: request intake and byte classification
// Classifies each accepted request and holds it in a two-entry queue
// that the decode back end drains.
// ----------------------------------------------------------------------------
module usd_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  usd_chan_if.sink          in_i,
  input  logic              pop_i,
  output usd_pkg::usd_head_t head_o
);
  import usd_pkg::*;

  usd_entry_t mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push;
  logic       do_pop;
  usd_entry_t cls;

  // Classify the incoming request
  always_comb begin
    cls.kind = K_BAD;
    cls.bits = '0;
    if (in_i.payload.operation == OP_FLUSH) begin
      cls.kind = K_FLUSH;
    end else begin
      case (in_i.payload.data_byte) inside
        [8'h00:8'h7F]: begin
          cls.kind = K_ASCII;
          cls.bits = in_i.payload.data_byte[6:0];
        end
        [8'h80:8'hBF]: begin
          cls.kind = K_CONT;
          cls.bits = {1'b0, in_i.payload.data_byte[5:0]};
        end
        [8'hC2:8'hDF]: begin
          cls.kind = K_LEAD2;
          cls.bits = {2'b00, in_i.payload.data_byte[4:0]};
        end
        [8'hE0:8'hEF]: begin
          cls.kind = K_LEAD3;
          cls.bits = {3'b000, in_i.payload.data_byte[3:0]};
        end
        [8'hF0:8'hF4]: begin
          cls.kind = K_LEAD4;
          cls.bits = {4'b0000, in_i.payload.data_byte[2:0]};
        end
        default: cls.kind = K_BAD;
      endcase
    end
  end

  // Queue control
  assign in_i.ready   = (count_q != 2'd2);
  assign push         = in_i.valid && in_i.ready;
  assign do_pop       = pop_i && (count_q != 2'd0);
  assign head_o.valid = (count_q != 2'd0);
  assign head_o.entry = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push   ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push && !do_pop) begin
      count_d = count_q + 2'd1;
    end else if (!push && do_pop) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= cls;
    end
  end

endmodule

>>> design/usd_back.sv
// ----------------------------------------------------------------------------
// usd_back: sequence decode and result register
// Holds the open-sequence state, consumes queue entries and drives the
// output register. An interrupted sequence before an ASCII or bad byte
// takes two passes over the same entry.
// ----------------------------------------------------------------------------
module usd_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  usd_pkg::usd_head_t head_i,
  output logic              pop_o,
  usd_chan_if.source        out_o
);
  import usd_pkg::*;

  logic [CpW-1:0]  part_q, part_d;
  logic [MinW-1:0] min_q, min_d;
  logic [1:0]      left_q, left_d;
  logic            ovld_q, ovld_d;
  usd_out_t        opay_q, opay_d;

  logic            slot_free;
  logic            step;
  logic            emit;
  logic [CpW-1:0]  emit_cp;
  logic            emit_last;
  logic [CpW-1:0]  joined;
  logic            bad_val;

  assign slot_free = !ovld_q || out_o.ready;
  assign step      = head_i.valid && slot_free;

  // Value after appending a continuation byte, and its legality
  assign joined  = {part_q[CpW-7:0], head_i.entry.bits[5:0]};
  assign bad_val = (joined < {4'b0000, min_q}) || (joined > MaxScalar) ||
                   ((joined >= SurrLo) && (joined <= SurrHi));

  // Decode step
  always_comb begin
    part_d    = part_q;
    min_d     = min_q;
    left_d    = left_q;
    pop_o     = 1'b0;
    emit      = 1'b0;
    emit_cp   = ReplacementCp;
    emit_last = 1'b1;
    if (step) begin
      pop_o = 1'b1;
      case (head_i.entry.kind)
        K_FLUSH: begin
          emit   = (left_q != 2'd0);
          part_d = '0;
          min_d  = '0;
          left_d = 2'd0;
        end
        K_CONT: begin
          if (left_q == 2'd0) begin
            emit = 1'b1;
          end else begin
            part_d = joined;
            left_d = left_q - 2'd1;
            if (left_q == 2'd1) begin
              emit    = 1'b1;
              emit_cp = bad_val ? ReplacementCp : joined;
              part_d  = '0;
              min_d   = '0;
            end
          end
        end
        K_LEAD2, K_LEAD3, K_LEAD4: begin
          // a pending sequence is cut short by the new lead
          emit   = (left_q != 2'd0);
          part_d = {{(CpW-BitsW){1'b0}}, head_i.entry.bits};
          if (head_i.entry.kind == K_LEAD2) begin
            min_d  = Min2;
            left_d = 2'd1;
          end else if (head_i.entry.kind == K_LEAD3) begin
            min_d  = Min3;
            left_d = 2'd2;
          end else begin
            min_d  = Min4;
            left_d = 2'd3;
          end
        end
        default: begin
          // ASCII or bad lead byte
          emit = 1'b1;
          if (left_q != 2'd0) begin
            // replacement first, then retry the same entry while idle
            emit_last = 1'b0;
            pop_o     = 1'b0;
            part_d    = '0;
            min_d     = '0;
            left_d    = 2'd0;
          end else if (head_i.entry.kind == K_ASCII) begin
            emit_cp = {{(CpW-BitsW){1'b0}}, head_i.entry.bits};
          end
        end
      endcase
    end
  end

  // Output register
  always_comb begin
    ovld_d = ovld_q;
    opay_d = opay_q;
    if (slot_free) begin
      ovld_d = emit;
      if (emit) begin
        opay_d.code_point  = emit_cp;
        opay_d.last_of_run = emit_last;
      end
    end
  end

  assign out_o.valid   = ovld_q;
  assign out_o.payload = opay_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      part_q <= '0;
      min_q  <= '0;
      left_q <= 2'd0;
      ovld_q <= 1'b0;
    end else begin
      part_q <= part_d;
      min_q  <= min_d;
      left_q <= left_d;
      ovld_q <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    opay_q <= opay_d;
  end

endmodule

>>> design/utf8_stream_decoder_unit.sv
// A request waits in the queue, then its result in the output register.
// Throughput: one request per cycle unless the queue is full; an interrupted
//   sequence before an ASCII or invalid byte takes two back-end passes.
// The input is decoupled from the output by a two-entry request queue.
// Reset: asynchronous, active low; clears the queue, decode state and
//   output valid.
// ----------------------------------------------------------------------------
// utf8_stream_decoder_unit: UTF-8 byte stream to Unicode code points
// Front end classifies bytes into a short queue; back end tracks the open
// sequence and emits code points with U+FFFD replacement.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  usd_chan_if.sink   in_i,
  usd_chan_if.source out_o
);
  import usd_pkg::*;

  usd_head_t head;
  logic      pop;

  usd_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .pop_i  (pop),
    .head_o (head)
  );

  usd_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .pop_o  (pop),
    .out_o  (out_o)
  );

endmodule

>>> tb/usd_decode_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usd_decode_check: code point predictor and result checker
// Watches both channels of the UTF-8 stream decoder, keeps its own copy of
// the open-sequence state, and compares every result against the oldest
// predicted code point.
// ----------------------------------------------------------------------------
module usd_decode_check (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  input  logic              req_ready_i,
  input  usd_pkg::usd_in_t  req_payload_i,
  input  logic              res_valid_i,
  input  logic              res_ready_i,
  input  usd_pkg::usd_out_t res_payload_i,
  output int unsigned       fail_count_o,
  output int unsigned       pending_o
);
  import usd_pkg::*;

  // Predicted state of the open sequence
  logic [CpW-1:0]  seq_value;
  logic [MinW-1:0] seq_min;
  logic [1:0]      conts_left;

  usd_out_t    cp_expected_q[$];
  int unsigned mismatches;

  function automatic void clear_seq();
    seq_value  = '0;
    seq_min    = '0;
    conts_left = '0;
  endfunction

  function automatic void push_cp(logic [CpW-1:0] cp);
    cp_expected_q.push_back('{code_point: cp, last_of_run: 1'b0});
  endfunction

  // Byte seen with no sequence open
  function automatic void open_sequence(logic [7:0] b);
    if (b <= 8'h7F) begin
      push_cp(CpW'(b));
    end else if (b >= 8'hC2 && b <= 8'hDF) begin
      seq_value  = CpW'(b[4:0]);
      seq_min    = Min2;
      conts_left = 2'd1;
    end else if (b >= 8'hE0 && b <= 8'hEF) begin
      seq_value  = CpW'(b[3:0]);
      seq_min    = Min3;
      conts_left = 2'd2;
    end else if (b >= 8'hF0 && b <= 8'hF4) begin
      seq_value  = CpW'(b[2:0]);
      seq_min    = Min4;
      conts_left = 2'd3;
    end else begin
      push_cp(ReplacementCp);
    end
  endfunction

  // Work out the code points one request produces
  function automatic void decode_request(usd_in_t req);
    int unsigned    size_before;
    usd_out_t       tail;
    logic [CpW-1:0] full;
    size_before = cp_expected_q.size();
    if (usd_op_e'(req.operation) == OP_FLUSH) begin
      if (conts_left != 2'd0) push_cp(ReplacementCp);
      clear_seq();
    end else if (conts_left == 2'd0) begin
      open_sequence(req.data_byte);
    end else if (req.data_byte[7:6] != 2'b10) begin
      // broken sequence: replace it, then decode the byte as if no sequence were open
      push_cp(ReplacementCp);
      clear_seq();
      open_sequence(req.data_byte);
    end else begin
      full       = {seq_value[CpW-7:0], req.data_byte[5:0]};
      seq_value  = full;
      conts_left = conts_left - 2'd1;
      if (conts_left == 2'd0) begin
        if (full < CpW'(seq_min) || full > MaxScalar || (full >= SurrLo && full <= SurrHi))
          push_cp(ReplacementCp);
        else
          push_cp(full);
        clear_seq();
      end
    end
    // flag the final code point of this request
    if (cp_expected_q.size() > size_before) begin
      tail = cp_expected_q.pop_back();
      tail.last_of_run = 1'b1;
      cp_expected_q.push_back(tail);
    end
  endfunction

  function automatic void check_result(usd_out_t got);
    usd_out_t want;
    if (cp_expected_q.size() == 0) begin
      $error("unexpected result: code_point %h last_of_run %b",
             got.code_point, got.last_of_run);
      mismatches++;
    end else begin
      want = cp_expected_q.pop_front();
      if (got.code_point !== want.code_point) begin
        $error("code_point: expected %h, got %h", want.code_point, got.code_point);
        mismatches++;
      end
      if (got.last_of_run !== want.last_of_run) begin
        $error("last_of_run: expected %b, got %b", want.last_of_run, got.last_of_run);
        mismatches++;
      end
    end
  endfunction

  // Predict on each accepted request, check each accepted result
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_seq();
      cp_expected_q.delete();
      mismatches = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (req_valid_i && req_ready_i) decode_request(req_payload_i);
      if (res_valid_i && res_ready_i) check_result(res_payload_i);
      fail_count_o <= mismatches;
      pending_o    <= cp_expected_q.size();
    end
  end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench top of the UTF-8 stream decoder
// Sends directed byte streams and then random UTF-8, mostly whole sequences
// (legal, overlong or out-of-range) with broken ones mixed in, under bursty
// requests and a stalling receiver; the checker judges every result.
// ----------------------------------------------------------------------------
module tb;
  import usd_pkg::*;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_RANDOM,
    STALL_SPARSE,
    STALL_PATTERN
  } stall_mode_e;

  logic        clk_i;
  logic        rst_ni;
  int unsigned fail_count;
  int unsigned pending;

  usd_chan_if #(.payload_t(usd_in_t))  req_ch ();
  usd_chan_if #(.payload_t(usd_out_t)) res_ch ();

  utf8_stream_decoder_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_ch),
    .out_o  (res_ch)
  );

  usd_decode_check u_cp_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_valid_i   (req_ch.valid),
    .req_ready_i   (req_ch.ready),
    .req_payload_i (req_ch.payload),
    .res_valid_i   (res_ch.valid),
    .res_ready_i   (res_ch.ready),
    .res_payload_i (res_ch.payload),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  // Clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Run limit
  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  // Receiver: stall mode is picked anew at random after each span
  stall_mode_e stall_mode = STALL_NONE;
  int unsigned stall_span = 0;
  logic [7:0]  stall_pat  = 8'b1011_0010;

  initial res_ch.ready = 1'b0;

  always @(posedge clk_i) begin
    if (stall_span == 0) begin
      stall_mode <= stall_mode_e'($urandom_range(0, 3));
      stall_span <= $urandom_range(20, 300);
    end else begin
      stall_span <= stall_span - 1;
    end
    stall_pat <= {stall_pat[6:0], stall_pat[7]};
    case (stall_mode)
      STALL_NONE:    res_ch.ready <= 1'b1;
      STALL_RANDOM:  res_ch.ready <= 1'($urandom_range(0, 1));
      STALL_SPARSE:  res_ch.ready <= ($urandom_range(0, 3) == 0);
      default:       res_ch.ready <= stall_pat[7];
    endcase
  end

  // Request stream
  usd_in_t     stim_q[$];
  int unsigned burst_left = 0;
  int unsigned sent_count = 0;

  function automatic void add_byte(logic [7:0] b);
    stim_q.push_back('{operation: OP_DATA, data_byte: b});
  endfunction

  function automatic void add_flush();
    stim_q.push_back('{operation: OP_FLUSH, data_byte: 8'($urandom)});
  endfunction

  // n-byte encoding of v, of which only the first keep bytes are queued
  function automatic void add_encoded(logic [20:0] v, int n, int keep);
    logic [7:0] enc [4];
    case (n)
      1: enc[0] = {1'b0, v[6:0]};
      2: begin
        enc[0] = {3'b110, v[10:6]};
        enc[1] = {2'b10, v[5:0]};
      end
      3: begin
        enc[0] = {4'b1110, v[15:12]};
        enc[1] = {2'b10, v[11:6]};
        enc[2] = {2'b10, v[5:0]};
      end
      default: begin
        enc[0] = {5'b11110, v[20:18]};
        enc[1] = {2'b10, v[17:12]};
        enc[2] = {2'b10, v[11:6]};
        enc[3] = {2'b10, v[5:0]};
      end
    endcase
    for (int i = 0; i < keep; i++) add_byte(enc[i]);
  endfunction

  function automatic logic [20:0] legal_value(int n);
    case (n)
      1:       return 21'($urandom_range(0, 'h7F));
      2:       return 21'($urandom_range('h80, 'h7FF));
      3:       return 21'($urandom_range('h800, 'hFFFF));
      default: return 21'($urandom_range('h10000, 'h10FFFF));
    endcase
  endfunction

  // One random group: mostly whole sequences, the rest errors and noise
  function automatic void add_random_group();
    int unsigned pick;
    int          n;
    logic [7:0]  b;
    pick = $urandom_range(0, 99);
    n    = $urandom_range(2, 4);
    if (pick < 45) begin
      n = $urandom_range(1, 4);
      add_encoded(legal_value(n), n, n);
    end else if (pick < 53) begin
      // overlong
      case (n)
        2:       add_encoded(21'($urandom_range(0, 'h7F)), 2, 2);
        3:       add_encoded(21'($urandom_range(0, 'h7FF)), 3, 3);
        default: add_encoded(21'($urandom_range(0, 'hFFFF)), 4, 4);
      endcase
    end else if (pick < 60) begin
      if ($urandom_range(0, 1))
        add_encoded(21'($urandom_range('hD800, 'hDFFF)), 3, 3);
      else
        add_encoded(21'($urandom_range('h110000, 'h13FFFF)), 4, 4);
    end else if (pick < 72) begin
      // sequence cut short by a byte that is not a continuation
      add_encoded(legal_value(n), n, $urandom_range(1, n - 1));
      b = 8'($urandom);
      if (b[7:6] == 2'b10) b[6] = 1'b1;
      add_byte(b);
    end else if (pick < 80) begin
      add_encoded(legal_value(n), n, $urandom_range(1, n - 1));
      add_flush();
    end else if (pick < 88) begin
      if ($urandom_range(0, 1)) begin
        add_byte(8'h80 | 8'($urandom_range(0, 'h3F)));
      end else begin
        b = 8'($urandom_range(0, 12));
        add_byte(b < 2 ? 8'hC0 + b : 8'hF5 + b - 8'd2);
      end
    end else if (pick < 92) begin
      add_flush();
    end else begin
      repeat ($urandom_range(1, 6)) add_byte(8'($urandom));
    end
  endfunction

  // Send one request, idling between bursts
  task automatic send_request(usd_in_t req);
    if (burst_left == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                                : $urandom_range(1, 20);
    end
    req_ch.valid   <= 1'b1;
    req_ch.payload <= req;
    do @(posedge clk_i); while (!req_ch.ready);
    burst_left--;
    sent_count++;
  endtask

  task automatic send_queued();
    while (stim_q.size() > 0) send_request(stim_q.pop_front());
  endtask

  initial begin
    rst_ni         <= 1'b0;
    req_ch.valid   <= 1'b0;
    req_ch.payload <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: field extremes, bad leads, boundaries and broken sequences
    add_byte(8'h00);
    add_flush();                          // flush with nothing open
    add_byte(8'h80);                      // stray continuation
    add_byte(8'hFF);                      // bad lead
    add_encoded(21'h000080, 2, 2);        // smallest two-byte value
    add_encoded(21'h10FFFF, 4, 4);        // largest scalar
    add_encoded(21'h00007F, 3, 3);        // overlong
    add_encoded(21'h00D800, 3, 3);        // surrogate
    add_encoded(21'h110000, 4, 4);        // above the scalar range
    add_byte(8'hE2);
    add_byte(8'h41);                      // cut short by ASCII
    add_byte(8'hF0);
    add_byte(8'h90);
    add_byte(8'hF8);                      // cut short by a bad lead
    add_byte(8'hC3);
    add_flush();                          // flush with a sequence open
    send_queued();

    // Random
    while (sent_count < 775) begin
      add_random_group();
      send_queued();
    end
    req_ch.valid <= 1'b0;

    // Drain
    do @(posedge clk_i); while (pending != 0);
    repeat (8) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
